// ===== rtl/core/utf16_to_utf8_encoder_defines.svh =====
// Assertion helpers for the encoder checker
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Concurrent check, held off while in reset
`define U16U8_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset
`define U16U8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/u16u8enc_pkg.sv =====
`timescale 1ns / 1ps

package u16u8enc_pkg;

  localparam int unsigned CfgAddrW = 4;

  localparam logic [1:0] RegCountOnly    = 2'd0;
  localparam logic [1:0] RegLimitEnabled = 2'd1;
  localparam logic [1:0] RegCapacity     = 2'd2;

  localparam int unsigned StepQDepth = 2;
  localparam int unsigned StepQPtrW  = $clog2(StepQDepth);

  typedef struct packed {
    logic        command;
    logic [15:0] code_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [31:0] total_length;
    logic        stopped;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        count_only;
    logic        limit_enabled;
    logic [31:0] capacity;
  } cfg_t;

  // One input item after encoding: up to six new bytes plus status
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      n;
    logic [31:0]     total;
    logic            stopped;
  } step_t;

endpackage

// ===== rtl/core/u16u8enc_front.sv =====
`timescale 1ns / 1ps

module u16u8enc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u16u8enc_pkg::cfg_t     cfg_i,
  input  logic                   accept_i,
  input  u16u8enc_pkg::in_item_t item_i,
  output u16u8enc_pkg::step_t    step_o
);

  localparam logic [7:0] Rep0 = 8'hEF;
  localparam logic [7:0] Rep1 = 8'hBF;
  localparam logic [7:0] Rep2 = 8'hBD;

  logic        pend_q, pend_d;
  logic [9:0]  lead_q, lead_d;
  logic [31:0] bw_q, bw_d;
  logic        stop_q, stop_d;

  logic [15:0]     c;
  logic            is_lead, is_trail, is_surr;
  logic [1:0]      fr_len;
  logic [2:0][7:0] fr_b;
  logic            fr_hold;
  logic [20:0]     cp;
  logic [2:0]      a_len;
  logic [3:0][7:0] a_b;
  logic            b_use;
  logic            a_is_pair;
  logic            limit_on;
  logic [31:0]     room;
  logic            ok_a, ok_b, b_exec, a_put, b_put;
  logic [2:0]      ab_len, add;
  logic [32:0]     sum;

  assign c        = item_i.code_unit;
  assign is_lead  = (c[15:10] == 6'b110110);
  assign is_trail = (c[15:10] == 6'b110111);
  assign is_surr  = is_lead | is_trail;
  assign cp       = {1'b0, lead_q, c[9:0]} + 21'h10000;
  assign limit_on = !cfg_i.count_only && cfg_i.limit_enabled;
  assign room     = (bw_q <= cfg_i.capacity) ? (cfg_i.capacity - bw_q) : 32'd0;

  // Encoding of a unit with no lead held
  always_comb begin
    fr_hold = 1'b0;
    fr_len  = 2'd0;
    fr_b    = '0;
    if (c[15:7] == 9'd0) begin
      fr_len  = 2'd1;
      fr_b[0] = c[7:0];
    end else if (c[15:11] == 5'd0) begin
      fr_len  = 2'd2;
      fr_b[0] = {3'b110, c[10:6]};
      fr_b[1] = {2'b10, c[5:0]};
    end else if (!is_surr) begin
      fr_len  = 2'd3;
      fr_b[0] = {4'b1110, c[15:12]};
      fr_b[1] = {2'b10, c[11:6]};
      fr_b[2] = {2'b10, c[5:0]};
    end else if (is_lead) begin
      fr_hold = 1'b1;
    end else begin
      fr_len  = 2'd3;
      fr_b[0] = Rep0;
      fr_b[1] = Rep1;
      fr_b[2] = Rep2;
    end
  end

  // First character: replacement or surrogate pair; second: fresh unit
  always_comb begin
    a_len     = 3'd0;
    a_b       = '0;
    b_use     = 1'b0;
    a_is_pair = 1'b0;
    if (!stop_q) begin
      if (item_i.command) begin
        if (pend_q) begin
          a_len = 3'd3;
          a_b   = {8'h00, Rep2, Rep1, Rep0};
        end
      end else if (pend_q && is_trail) begin
        a_len     = 3'd4;
        a_is_pair = 1'b1;
        a_b       = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {2'b10, cp[17:12]},
                     {5'b11110, cp[20:18]}};
      end else if (pend_q) begin
        a_len = 3'd3;
        a_b   = {8'h00, Rep2, Rep1, Rep0};
        b_use = 1'b1;
      end else begin
        b_use = 1'b1;
      end
    end
  end

  assign ab_len = a_len + {1'b0, fr_len};
  assign ok_a   = !limit_on || (room[31:3] != 29'd0) || (room[2:0] >= a_len);
  assign ok_b   = !limit_on || (room[31:3] != 29'd0) || (room[2:0] >= ab_len);
  assign b_exec = b_use && ok_a;
  assign a_put  = (a_len != 3'd0) && ok_a;
  assign b_put  = b_exec && (fr_len != 2'd0) && ok_b;
  assign add    = (a_put ? a_len : 3'd0) + (b_put ? {1'b0, fr_len} : 3'd0);
  assign sum    = {1'b0, bw_q} + {30'd0, add};

  always_comb begin
    bw_d   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    stop_d = stop_q || ((a_len != 3'd0) && !ok_a) ||
             (b_exec && (fr_len != 2'd0) && !ok_b);
    pend_d = pend_q;
    lead_d = lead_q;
    if (!stop_q) begin
      if (item_i.command) begin
        pend_d = 1'b0;
      end else if (pend_q && a_is_pair) begin
        if (ok_a) pend_d = 1'b0;
      end else if (b_exec) begin
        pend_d = fr_hold;
        if (fr_hold) lead_d = c[9:0];
      end
    end
  end

  always_comb begin
    step_o.bytes   = '0;
    step_o.n       = cfg_i.count_only ? 3'd0 : add;
    step_o.total   = bw_d;
    step_o.stopped = stop_d;
    if (a_put) begin
      step_o.bytes[0] = a_b[0];
      step_o.bytes[1] = a_b[1];
      step_o.bytes[2] = a_b[2];
      step_o.bytes[3] = a_is_pair ? a_b[3] : fr_b[0];
      step_o.bytes[4] = fr_b[1];
      step_o.bytes[5] = fr_b[2];
    end else begin
      step_o.bytes[0] = fr_b[0];
      step_o.bytes[1] = fr_b[1];
      step_o.bytes[2] = fr_b[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      lead_q <= '0;
      bw_q   <= '0;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      lead_q <= lead_d;
      bw_q   <= bw_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ===== rtl/core/u16u8enc_fifo.sv =====
`timescale 1ns / 1ps

module u16u8enc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  u16u8enc_pkg::step_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output u16u8enc_pkg::step_t data_o,
  output logic                empty_o
);

  localparam int unsigned CntW = $clog2(u16u8enc_pkg::StepQDepth + 1);
  localparam logic [u16u8enc_pkg::StepQPtrW-1:0] LastPtr =
    u16u8enc_pkg::StepQPtrW'(u16u8enc_pkg::StepQDepth - 1);

  u16u8enc_pkg::step_t mem_q [u16u8enc_pkg::StepQDepth];

  logic [u16u8enc_pkg::StepQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                    cnt_q;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(u16u8enc_pkg::StepQDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/u16u8enc_back.sv =====
`timescale 1ns / 1ps

module u16u8enc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_valid_i,
  input  u16u8enc_pkg::step_t     step_i,
  output logic                    step_pop_o,
  output logic                    out_valid_o,
  output u16u8enc_pkg::out_item_t out_item_o,
  input  logic                    out_pop_i
);

  logic [7:0][7:0] buf_q, buf_d, w_buf, cmb_buf;
  logic [3:0]      buf_n_q, buf_n_d, w_n, cmb_tot;
  logic [2:0]      left_q, left_d, w_left;
  logic            stat_q, stat_d, w_stat;
  logic [31:0]     total_q, w_total;
  logic            stop_q, w_stop;
  logic            out_valid_q, out_valid_d;
  u16u8enc_pkg::out_item_t out_q, out_d;
  logic            out_free, load, emit;

  assign out_free   = !out_valid_q || out_pop_i;
  assign load       = (left_q == 3'd0) && !stat_q && step_valid_i && out_free;
  assign step_pop_o = load;
  assign cmb_tot    = buf_n_q + {1'b0, step_i.n};

  // backlog bytes first, then this item's bytes
  always_comb begin
    cmb_buf = buf_q;
    case (buf_n_q[1:0])
      2'd0: begin
        for (int i = 0; i < 6; i++) cmb_buf[i] = step_i.bytes[i];
      end
      2'd1: begin
        for (int i = 0; i < 6; i++) cmb_buf[i+1] = step_i.bytes[i];
      end
      default: begin
        for (int i = 0; i < 6; i++) cmb_buf[i+2] = step_i.bytes[i];
      end
    endcase
  end

  always_comb begin
    if (load) begin
      w_buf   = cmb_buf;
      w_n     = cmb_tot;
      w_left  = (cmb_tot > 4'd4) ? 3'd4 : cmb_tot[2:0];
      w_stat  = (cmb_tot == 4'd0);
      w_total = step_i.total;
      w_stop  = step_i.stopped;
    end else begin
      w_buf   = buf_q;
      w_n     = buf_n_q;
      w_left  = left_q;
      w_stat  = stat_q;
      w_total = total_q;
      w_stop  = stop_q;
    end
  end

  assign emit = out_free && ((w_left != 3'd0) || w_stat);

  always_comb begin
    buf_d       = w_buf;
    buf_n_d     = w_n;
    left_d      = w_left;
    stat_d      = w_stat;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_pop_i) out_valid_d = 1'b0;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.total_length  = w_total;
      out_d.stopped       = w_stop;
      if (w_stat) begin
        stat_d           = 1'b0;
        out_d.out_byte   = 8'h00;
        out_d.byte_valid = 1'b0;
        out_d.last       = 1'b1;
      end else begin
        out_d.out_byte   = w_buf[0];
        out_d.byte_valid = 1'b1;
        out_d.last       = (w_left == 3'd1);
        for (int i = 0; i < 7; i++) buf_d[i] = w_buf[i+1];
        buf_n_d = w_n - 4'd1;
        left_d  = w_left - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    total_q <= w_total;
    stop_q  <= w_stop;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_n_q     <= '0;
      left_q      <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_n_q     <= buf_n_d;
      left_q      <= left_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/utf16_to_utf8_encoder.sv =====
`timescale 1ns / 1ps
// UTF-16 to UTF-8 encoder.
// Input queue: push/full carries one item (command, code_unit) per accepted edge.
// Result queue: empty/pop; the oldest result sits on out_item_o while empty is low.
// Each item gives one result per UTF-8 byte (at most four, surplus bytes go out
// first with the next item), or one status-only result when no byte comes out.
// An accepted item's step is queued, then its first result is registered as output.
// Throughput: the result side moves one result item per cycle unless pop is held low;
// an item that gives no byte still takes one status-only result. The front end takes
// an item per cycle into a two-entry queue and stalls only when that queue fills.
// Holding pop low stalls the result register, then the queue, then push via full.
// Reset clears the held lead, byte count, stop flag, backlog and the config registers
// (count_only, limit_enabled and capacity read back as zero).
// Registers (APB, byte address): 0x0 count_only, 0x4 limit_enabled, 0x8 capacity;
// write them only while the block is idle.

module utf16_to_utf8_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [u16u8enc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                push,
  output logic                                full,
  input  u16u8enc_pkg::in_item_t              in_item_i,
  output logic                                empty,
  input  logic                                pop,
  output u16u8enc_pkg::out_item_t             out_item_o
);

  logic        count_only_q, limit_enabled_q;
  logic [31:0] capacity_q;
  logic        cfg_wr;
  logic        accept;
  logic        q_full, q_empty, q_pop;
  logic        out_valid;
  u16u8enc_pkg::cfg_t  cfg;
  u16u8enc_pkg::step_t step_in, step_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_only_q    <= 1'b0;
      limit_enabled_q <= 1'b0;
      capacity_q      <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        u16u8enc_pkg::RegCountOnly:    count_only_q    <= pwdata[0];
        u16u8enc_pkg::RegLimitEnabled: limit_enabled_q <= pwdata[0];
        u16u8enc_pkg::RegCapacity:     capacity_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      u16u8enc_pkg::RegCountOnly:    prdata = {31'd0, count_only_q};
      u16u8enc_pkg::RegLimitEnabled: prdata = {31'd0, limit_enabled_q};
      u16u8enc_pkg::RegCapacity:     prdata = capacity_q;
      default:                       prdata = '0;
    endcase
  end

  assign cfg.count_only    = count_only_q;
  assign cfg.limit_enabled = limit_enabled_q;
  assign cfg.capacity      = capacity_q;

  assign full   = q_full;
  assign accept = push && !q_full;

  u16u8enc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .item_i   (in_item_i),
    .step_o   (step_in)
  );

  u16u8enc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (step_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (step_out),
    .empty_o (q_empty)
  );

  u16u8enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (!q_empty),
    .step_i       (step_out),
    .step_pop_o   (q_pop),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item_o),
    .out_pop_i    (pop && out_valid)
  );

  assign empty = !out_valid;

endmodule

// ===== rtl/core/u16u8enc_checker.sv =====
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_defines.svh"

module u16u8enc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input u16u8enc_pkg::out_item_t           out_item_o
);

  `U16U8_ASSERT_ALWAYS(a_empty_after_reset, clk_i, $rose(rst_ni) |-> empty, "result queue not empty after reset")

  `U16U8_ASSERT(a_result_held, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "stalled item changed")

  `U16U8_ASSERT(a_status_is_last, clk_i, rst_ni, (!empty && !out_item_o.byte_valid) |-> out_item_o.last, "status-only item not marked last")

  `U16U8_ASSERT(a_stop_sticky, clk_i, rst_ni, (!empty && pop && out_item_o.stopped) |=> (empty || out_item_o.stopped), "stop flag cleared")

  `U16U8_ASSERT(a_length_monotonic, clk_i, rst_ni, (!empty && pop) |=> (empty || (out_item_o.total_length >= $past(out_item_o.total_length))), "byte count went down")

endmodule

bind utf16_to_utf8_encoder u16u8enc_checker u_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic CmdEncode = 1'b0;
  localparam logic CmdFinish = 1'b1;
  localparam logic [15:0] LeadLo  = 16'hD800;
  localparam logic [15:0] TrailLo = 16'hDC00;
  localparam logic [15:0] TrailHi = 16'hDFFF;
  localparam int IdlePct = 35;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [u16u8enc_pkg::CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push = 1'b0;
  logic                full;
  u16u8enc_pkg::in_item_t in_item_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  u16u8enc_pkg::out_item_t out_item_o;

  utf16_to_utf8_encoder dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .in_item_i, .empty, .pop, .out_item_o
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic        cfg_count_only = 1'b0;
  logic        cfg_limit_en = 1'b0;
  logic [31:0] cfg_capacity = '0;
  logic        lead_held = 1'b0;
  logic [9:0]  lead_bits = '0;
  logic [31:0] byte_count = '0;
  logic        halted = 1'b0;
  logic [7:0]  spill_bytes[$];
  logic [7:0]  char_bytes[$];
  u16u8enc_pkg::out_item_t utf8_due[$];

  int          errors = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_len = 0;
  int          hold_left = 0;
  u16u8enc_pkg::out_item_t want;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic bit put_char(input logic [7:0] b [4], input int n);
    logic [31:0] room;
    if (halted) return 1'b0;
    if (!cfg_count_only && cfg_limit_en) begin
      room = (byte_count <= cfg_capacity) ? cfg_capacity - byte_count : 32'd0;
      if (room < n) begin
        halted = 1'b1;
        return 1'b0;
      end
    end
    if (32'hFFFF_FFFF - byte_count < n) byte_count = '1;
    else byte_count = byte_count + n;
    if (!cfg_count_only) begin
      for (int i = 0; i < n; i++) char_bytes.push_back(b[i]);
    end
    return 1'b1;
  endfunction

  function automatic bit put_fffd();
    logic [7:0] b [4];
    b = '{8'hEF, 8'hBF, 8'hBD, 8'h00};
    return put_char(b, 3);
  endfunction

  function automatic void encode_fresh(input logic [15:0] c);
    logic [7:0] b [4];
    b = '{default: 8'h00};
    if (c < 16'h0080) begin
      b[0] = c[7:0];
      void'(put_char(b, 1));
    end else if (c < 16'h0800) begin
      b[0] = {3'b110, c[10:6]};
      b[1] = {2'b10, c[5:0]};
      void'(put_char(b, 2));
    end else if (c < LeadLo || c > TrailHi) begin
      b[0] = {4'b1110, c[15:12]};
      b[1] = {2'b10, c[11:6]};
      b[2] = {2'b10, c[5:0]};
      void'(put_char(b, 3));
    end else if (c < TrailLo) begin
      lead_held = 1'b1;
      lead_bits = c[9:0];
    end else begin
      void'(put_fffd());
    end
  endfunction

  function automatic void encode_item(input u16u8enc_pkg::in_item_t it);
    int          k;
    u16u8enc_pkg::out_item_t r;
    logic [7:0]  b [4];
    logic [20:0] cp;
    char_bytes = spill_bytes;
    spill_bytes.delete();
    if (!halted) begin
      if (it.command == CmdFinish) begin
        if (lead_held) begin
          lead_held = 1'b0;
          lead_bits = '0;
          void'(put_fffd());
        end
      end else if (lead_held) begin
        if (it.code_unit >= TrailLo && it.code_unit <= TrailHi) begin
          cp = 21'h10000 + {1'b0, lead_bits, it.code_unit[9:0]};
          b[0] = {5'b11110, cp[20:18]};
          b[1] = {2'b10, cp[17:12]};
          b[2] = {2'b10, cp[11:6]};
          b[3] = {2'b10, cp[5:0]};
          if (put_char(b, 4)) begin
            lead_held = 1'b0;
            lead_bits = '0;
          end
        end else if (put_fffd()) begin
          lead_held = 1'b0;
          lead_bits = '0;
          encode_fresh(it.code_unit);
        end
      end else begin
        encode_fresh(it.code_unit);
      end
    end
    r.total_length = byte_count;
    r.stopped = halted;
    if (char_bytes.size() == 0) begin
      r.out_byte = '0;
      r.byte_valid = 1'b0;
      r.last = 1'b1;
      utf8_due.push_back(r);
    end else begin
      k = (char_bytes.size() < 4) ? char_bytes.size() : 4;
      for (int i = 0; i < k; i++) begin
        r.out_byte = char_bytes[i];
        r.byte_valid = 1'b1;
        r.last = (i == k - 1);
        utf8_due.push_back(r);
      end
      for (int i = k; i < char_bytes.size(); i++) spill_bytes.push_back(char_bytes[i]);
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [15:0] unit);
    u16u8enc_pkg::in_item_t it;
    it.command = cmd;
    it.code_unit = unit;
    if (gaps_on && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    encode_item(it);
  endtask

  task automatic send_random(input int count);
    int sent;
    int kind;
    logic [15:0] u;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 22) begin
        send_item(CmdEncode, 16'($urandom_range(16'h007F)));
        sent++;
      end else if (kind < 37) begin
        send_item(CmdEncode, 16'($urandom_range(16'h07FF, 16'h0080)));
        sent++;
      end else if (kind < 55) begin
        if ($urandom_range(1)) u = 16'($urandom_range(16'hD7FF, 16'h0800));
        else u = 16'($urandom_range(16'hFFFF, 16'hE000));
        send_item(CmdEncode, u);
        sent++;
      end else if (kind < 77) begin
        send_item(CmdEncode, 16'($urandom_range(16'hDBFF, 16'hD800)));
        send_item(CmdEncode, 16'($urandom_range(16'hDFFF, 16'hDC00)));
        sent += 2;
      end else if (kind < 84) begin
        send_item(CmdFinish, 16'($urandom));
        sent++;
      end else if (kind < 91) begin
        send_item(CmdEncode, 16'($urandom_range(16'hDFFF, 16'hD800)));
        sent++;
      end else begin
        send_item(CmdEncode, 16'($urandom));
        sent++;
      end
    end
  endtask

  // lower push after the last item, then let the block drain
  task automatic wait_idle(input int tail);
    push <= 1'b0;
    @(posedge clk_i);
    while (utf8_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] value,
                            output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= u16u8enc_pkg::CfgAddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_set(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_access(1'b1, idx, value, rd);
    case (idx)
      u16u8enc_pkg::RegCountOnly: begin
        cfg_count_only = value[0];
        mask = 32'h1;
      end
      u16u8enc_pkg::RegLimitEnabled: begin
        cfg_limit_en = value[0];
        mask = 32'h1;
      end
      default: begin
        cfg_capacity = value;
        mask = '1;
      end
    endcase
    apb_access(1'b0, idx, '0, rd);
    if (rd !== (value & mask))
      flag_error($sformatf("reg %0d readback: want %08h got %08h", idx, value & mask, rd));
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= !gaps_on || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (utf8_due.size() == 0) begin
        flag_error($sformatf("unexpected item: byte %02h valid %0b len %0d stop %0b last %0b",
                             out_item_o.out_byte, out_item_o.byte_valid,
                             out_item_o.total_length, out_item_o.stopped, out_item_o.last));
      end else begin
        want = utf8_due.pop_front();
        if (out_item_o.out_byte !== want.out_byte ||
            out_item_o.byte_valid !== want.byte_valid ||
            out_item_o.total_length !== want.total_length ||
            out_item_o.stopped !== want.stopped ||
            out_item_o.last !== want.last)
          flag_error($sformatf({"want byte %02h valid %0b len %0d stop %0b last %0b, ",
                                "got byte %02h valid %0b len %0d stop %0b last %0b"},
                               want.out_byte, want.byte_valid, want.total_length,
                               want.stopped, want.last,
                               out_item_o.out_byte, out_item_o.byte_valid,
                               out_item_o.total_length, out_item_o.stopped,
                               out_item_o.last));
      end
    end
  end

  task automatic test_directed();
    cfg_set(u16u8enc_pkg::RegCountOnly, 32'd0);
    cfg_set(u16u8enc_pkg::RegLimitEnabled, 32'd0);
    cfg_set(u16u8enc_pkg::RegCapacity, 32'd0);
    send_item(CmdEncode, 16'h0000);
    send_item(CmdEncode, 16'h007F);
    send_item(CmdEncode, 16'h0080);
    send_item(CmdEncode, 16'h07FF);
    send_item(CmdEncode, 16'h0800);
    send_item(CmdEncode, 16'hD7FF);
    send_item(CmdEncode, 16'hE000);
    send_item(CmdEncode, 16'hFFFF);
    send_item(CmdEncode, 16'hD800);
    send_item(CmdEncode, 16'hDC00);
    send_item(CmdEncode, 16'hDBFF);
    send_item(CmdEncode, 16'hDFFF);
    // lone trails
    send_item(CmdEncode, 16'hDC00);
    send_item(CmdEncode, 16'hDFFF);
    // lead then a plain unit
    send_item(CmdEncode, 16'hD800);
    send_item(CmdEncode, 16'h0041);
    // lead then lead, then a trail
    send_item(CmdEncode, 16'hD800);
    send_item(CmdEncode, 16'hDBFF);
    send_item(CmdEncode, 16'hDC00);
    // six bytes: two spill into the next item
    send_item(CmdEncode, 16'hD900);
    send_item(CmdEncode, 16'h0800);
    send_item(CmdFinish, 16'h0000);
    // finish flushes a held lead
    send_item(CmdEncode, 16'hDA55);
    send_item(CmdFinish, 16'hFFFF);
    send_item(CmdFinish, 16'h5A5A);
    wait_idle(8);
  endtask

  task automatic test_fill_and_stall();
    gaps_on = 1'b0;
    hold_len = 300;
    hold_req = ~hold_req;
    for (int i = 0; i < 30; i++) send_item(CmdEncode, 16'($urandom_range(16'hD7FF, 16'h0800)));
    wait_idle(8);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_emit();
    send_random(120);
    send_item(CmdFinish, 16'h0000);
    wait_idle(8);
  endtask

  task automatic test_random_count_only();
    cfg_set(u16u8enc_pkg::RegCountOnly, 32'd1);
    cfg_set(u16u8enc_pkg::RegLimitEnabled, 32'd1);
    cfg_set(u16u8enc_pkg::RegCapacity, 32'd0);
    gaps_on = 1'b0;
    send_random(80);
    send_item(CmdFinish, 16'h0000);
    wait_idle(8);
    gaps_on = 1'b1;
  endtask

  task automatic test_limit_wide();
    cfg_set(u16u8enc_pkg::RegCountOnly, 32'd0);
    cfg_set(u16u8enc_pkg::RegCapacity, 32'hFFFF_FFFF);
    send_random(80);
    send_item(CmdFinish, 16'h0000);
    wait_idle(8);
  endtask

  // stop is sticky until reset, so this runs last
  task automatic test_limit_stop();
    cfg_set(u16u8enc_pkg::RegCapacity, byte_count + 32'd6);
    send_item(CmdEncode, 16'hD800);
    send_item(CmdEncode, 16'h0800);
    wait_idle(8);
    // count now equals capacity, then lies above it; the spilled bytes still drain
    cfg_set(u16u8enc_pkg::RegCapacity, 32'd0);
    send_item(CmdEncode, 16'h0041);
    send_random(30);
    send_item(CmdFinish, 16'h0000);
    wait_idle(20);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_stall();
    test_random_emit();
    test_random_count_only();
    test_limit_wide();
    test_limit_stop();
    if (errors == 0) begin
      $display("utf16_to_utf8_encoder regression: pass");
    end else begin
      $display("utf16_to_utf8_encoder regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("utf16_to_utf8_encoder regression: fail");
    $finish;
  end

endmodule
